// File: rtl/skk_pkg.sv
// Shared constants, command encodings and controller states for the 2-state Kalman estimator.
package skk_pkg;

	localparam int DW     = 32;            // datapath word width
	localparam int FRAC   = 24;            // fraction bits
	localparam int IO_W   = 32;            // width of stream fields
	localparam int CFG_W  = 64;            // config register width
	localparam int HALF_W = CFG_W / 2;     // one packed coefficient slot
	localparam int IDX_W  = 3;             // config index width
	localparam int PROD_W = 2 * DW;        // full product
	localparam int SH_W   = PROD_W - FRAC; // product after the fraction shift
	localparam int ACC_W  = SH_W + 2;      // three-term sum without overflow

	typedef enum logic [IDX_W-1:0] {
		REG_A_ROW0     = 3'd0,
		REG_A_ROW1     = 3'd1,
		REG_B          = 3'd2,
		REG_C          = 3'd3,
		REG_K          = 3'd4,
		REG_INIT_STATE = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		MUL_NONE,
		MUL_C0_X0,
		MUL_C1_X1,
		MUL_K0_E,
		MUL_K1_E,
		MUL_A00_XC0,
		MUL_A01_XC1,
		MUL_B0_U,
		MUL_A10_XC0,
		MUL_A11_XC1,
		MUL_B1_U
	} mul_sel_t;

	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD,
		ACC_INNOV,
		ACC_X0,
		ACC_X1
	} acc_op_t;

	typedef enum logic [2:0] {
		SAVE_NONE,
		SAVE_E,
		SAVE_XC0,
		SAVE_XC1,
		SAVE_N0,
		SAVE_N1
	} save_t;

	typedef struct packed {
		logic     start;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		save_t    save;
	} cmd_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CX0,
		ST_CX1,
		ST_CXA,
		ST_INNOV,
		ST_E,
		ST_K0,
		ST_K1,
		ST_XC0,
		ST_XC1,
		ST_P01,
		ST_P0B,
		ST_P10,
		ST_P11,
		ST_P1B,
		ST_P1A,
		ST_DONE
	} ctrl_state_t;

endpackage

// File: rtl/skk_ctrl.sv
// Sequencer: steps one request through the shared multiplier and accumulator.
module skk_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output skk_pkg::cmd_t cmd
);
	import skk_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.save == SAVE_N1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_CX0;
			ST_CX0:   state_d = ST_CX1;
			ST_CX1:   state_d = ST_CXA;
			ST_CXA:   state_d = ST_INNOV;
			ST_INNOV: state_d = ST_E;
			ST_E:     state_d = ST_K0;
			ST_K0:    state_d = ST_K1;
			ST_K1:    state_d = ST_XC0;
			ST_XC0:   state_d = ST_XC1;
			ST_XC1:   state_d = ST_P01;
			ST_P01:   state_d = ST_P0B;
			ST_P0B:   state_d = ST_P10;
			ST_P10:   state_d = ST_P11;
			ST_P11:   state_d = ST_P1B;
			ST_P1B:   state_d = ST_P1A;
			ST_P1A:   state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// product is registered, so the accumulator consumes it in the state after the multiply
	always_comb begin
		cmd.start   = 1'b0;
		cmd.mul_sel = MUL_NONE;
		cmd.acc_op  = ACC_HOLD;
		cmd.save    = SAVE_NONE;
		unique case (state_q)
			ST_IDLE:  cmd.start = in_valid;
			ST_CX0:   cmd.mul_sel = MUL_C0_X0;
			ST_CX1: begin
				cmd.mul_sel = MUL_C1_X1;
				cmd.acc_op  = ACC_LOAD;
			end
			ST_CXA:   cmd.acc_op = ACC_ADD;
			ST_INNOV: cmd.acc_op = ACC_INNOV;
			ST_E:     cmd.save = SAVE_E;
			ST_K0:    cmd.mul_sel = MUL_K0_E;
			ST_K1: begin
				cmd.mul_sel = MUL_K1_E;
				cmd.acc_op  = ACC_X0;
			end
			ST_XC0: begin
				cmd.save   = SAVE_XC0;
				cmd.acc_op = ACC_X1;
			end
			ST_XC1: begin
				cmd.save    = SAVE_XC1;
				cmd.mul_sel = MUL_A00_XC0;
			end
			ST_P01: begin
				cmd.mul_sel = MUL_A01_XC1;
				cmd.acc_op  = ACC_LOAD;
			end
			ST_P0B: begin
				cmd.mul_sel = MUL_B0_U;
				cmd.acc_op  = ACC_ADD;
			end
			ST_P10: begin
				cmd.mul_sel = MUL_A10_XC0;
				cmd.acc_op  = ACC_ADD;
			end
			ST_P11: begin
				cmd.mul_sel = MUL_A11_XC1;
				cmd.save    = SAVE_N0;
				cmd.acc_op  = ACC_LOAD;
			end
			ST_P1B: begin
				cmd.mul_sel = MUL_B1_U;
				cmd.acc_op  = ACC_ADD;
			end
			ST_P1A:   cmd.acc_op = ACC_ADD;
			ST_DONE:  if (out_free) cmd.save = SAVE_N1;
			default:  cmd.start = 1'b0;
		endcase
	end

endmodule

// File: rtl/skk_dp.sv
// Datapath: coefficients, state, one shared multiplier, saturating accumulator, result register.
module skk_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  skk_pkg::cmd_t               cmd,
	input  logic                        cfg_we,
	input  logic [skk_pkg::IDX_W-1:0]   cfg_index,
	input  logic [skk_pkg::CFG_W-1:0]   cfg_data,
	input  logic [skk_pkg::IO_W-1:0]    drive_input,
	input  logic [skk_pkg::IO_W-1:0]    measurement,
	output logic [skk_pkg::IO_W-1:0]    estimate,
	output logic                        saturated
);
	import skk_pkg::*;

	logic signed [DW-1:0]     a00_q, a01_q, a10_q, a11_q, b0_q, b1_q, c0_q, c1_q, k0_q, k1_q;
	logic signed [DW-1:0]     x0_q, x1_q;
	logic signed [DW-1:0]     u_q, y_q, e_q, xc0_q, xc1_q, n0_q;
	logic signed [DW-1:0]     op_a, op_b;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [SH_W-1:0]   prod_sh;
	logic signed [ACC_W-1:0]  acc_q, acc_d;
	logic signed [DW-1:0]     acc_sat;
	logic                     acc_clip;
	logic                     sat_q;
	logic [IO_W-1:0]          out_data_q;
	logic                     out_sat_q;

	assign estimate  = out_data_q;
	assign saturated = out_sat_q;

	// floor shift: drop the fraction bits of the full product
	assign prod_sh = $signed(prod_q[PROD_W-1:FRAC]);

	// clipped when the sign position and the bits above it disagree
	assign acc_clip = !((&acc_q[ACC_W-1:DW-1]) || !(|acc_q[ACC_W-1:DW-1]));
	assign acc_sat  = acc_clip ? $signed({acc_q[ACC_W-1], {(DW-1){~acc_q[ACC_W-1]}}})
	                           : $signed(acc_q[DW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a00_q <= '0; a01_q <= '0; a10_q <= '0; a11_q <= '0;
			b0_q  <= '0; b1_q  <= '0; c0_q  <= '0; c1_q  <= '0;
			k0_q  <= '0; k1_q  <= '0;
			x0_q  <= '0; x1_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_A_ROW0: begin
					a00_q <= cfg_data[DW-1:0];
					a01_q <= cfg_data[HALF_W +: DW];
				end
				REG_A_ROW1: begin
					a10_q <= cfg_data[DW-1:0];
					a11_q <= cfg_data[HALF_W +: DW];
				end
				REG_B: begin
					b0_q <= cfg_data[DW-1:0];
					b1_q <= cfg_data[HALF_W +: DW];
				end
				REG_C: begin
					c0_q <= cfg_data[DW-1:0];
					c1_q <= cfg_data[HALF_W +: DW];
				end
				REG_K: begin
					k0_q <= cfg_data[DW-1:0];
					k1_q <= cfg_data[HALF_W +: DW];
				end
				REG_INIT_STATE: begin
					x0_q <= cfg_data[DW-1:0];
					x1_q <= cfg_data[HALF_W +: DW];
				end
				default: ;
			endcase
		end else if (cmd.save == SAVE_N1) begin
			x0_q <= n0_q;
			x1_q <= acc_sat;
		end
	end

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (cmd.mul_sel)
			MUL_C0_X0:   begin op_a = c0_q;  op_b = x0_q;  end
			MUL_C1_X1:   begin op_a = c1_q;  op_b = x1_q;  end
			MUL_K0_E:    begin op_a = k0_q;  op_b = e_q;   end
			MUL_K1_E:    begin op_a = k1_q;  op_b = e_q;   end
			MUL_A00_XC0: begin op_a = a00_q; op_b = xc0_q; end
			MUL_A01_XC1: begin op_a = a01_q; op_b = xc1_q; end
			MUL_B0_U:    begin op_a = b0_q;  op_b = u_q;   end
			MUL_A10_XC0: begin op_a = a10_q; op_b = xc0_q; end
			MUL_A11_XC1: begin op_a = a11_q; op_b = xc1_q; end
			MUL_B1_U:    begin op_a = b1_q;  op_b = u_q;   end
			default:     begin op_a = '0;    op_b = '0;    end
		endcase
	end

	always_comb begin
		case (cmd.acc_op)
			ACC_LOAD:  acc_d = ACC_W'(prod_sh);
			ACC_ADD:   acc_d = acc_q + ACC_W'(prod_sh);
			ACC_INNOV: acc_d = ACC_W'(y_q) - ACC_W'(acc_sat);
			ACC_X0:    acc_d = ACC_W'(x0_q) + ACC_W'(prod_sh);
			ACC_X1:    acc_d = ACC_W'(x1_q) + ACC_W'(prod_sh);
			default:   acc_d = acc_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= 1'b0;
		end else if (cmd.start) begin
			sat_q <= 1'b0;
		end else if (cmd.acc_op == ACC_INNOV || cmd.save != SAVE_NONE) begin
			sat_q <= sat_q | acc_clip;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
		acc_q  <= acc_d;
		if (cmd.start) begin
			u_q <= $signed(drive_input[DW-1:0]);
			y_q <= $signed(measurement[DW-1:0]);
		end
		case (cmd.save)
			SAVE_E:   e_q   <= acc_sat;
			SAVE_XC0: xc0_q <= acc_sat;
			SAVE_XC1: xc1_q <= acc_sat;
			SAVE_N0:  n0_q  <= acc_sat;
			SAVE_N1: begin
				out_data_q <= IO_W'(n0_q);
				out_sat_q  <= sat_q | acc_clip;
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/steady_state_kalman_2state.sv
// Top level of the two-state steady-state Kalman estimator.
//
//  channel   signals                          contents
//  s_axis    tvalid tready tdata[63:0]        request: drive_input, measurement
//  m_axis    tvalid tready tdata[31:0] tuser  result: estimate, saturated flag
//  cfg       cfg_we cfg_index cfg_data[63:0]  coefficient / initial state writes
//
// A request is worked on alone: the input is closed from accept until its result is
// committed to the output register. All ten products share one registered 32x32
// multiplier, and each sum waits on the one before. A new request is taken in the
// cycle after the previous result is registered, while that result may still wait
// in the output register.
// A stalled output holds the controller in its final step. arst_n clears state
// and all coefficients to zero; writing initial_state loads the estimate state.
module steady_state_kalman_2state (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [63:0]               s_axis_tdata,   // [31:0] drive_input, [63:32] measurement
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [skk_pkg::IO_W-1:0]  m_axis_tdata,   // [31:0] estimate
	output logic                      m_axis_tuser,   // [0] saturated
	input  logic                      cfg_we,
	input  logic [skk_pkg::IDX_W-1:0] cfg_index,
	input  logic [skk_pkg::CFG_W-1:0] cfg_data
);
	import skk_pkg::*;

	cmd_t cmd;

	skk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	skk_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.drive_input (s_axis_tdata[IO_W-1:0]),
		.measurement (s_axis_tdata[2*IO_W-1:IO_W]),
		.estimate    (m_axis_tdata),
		.saturated   (m_axis_tuser)
	);

	// an accepted request keeps the input closed while it is worked on
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input ready right after accept");

	// a result appears only from the final commit step
	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(cmd.save == SAVE_N1))
		else $error("result valid without commit");

	// after commit the block is open for the next request
	a_idle_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.save == SAVE_N1) |=> (s_axis_tready && m_axis_tvalid))
		else $error("not idle with result after commit");

	// a request start only happens in the idle step
	a_start_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> (s_axis_tready && s_axis_tvalid))
		else $error("start outside of accept");

endmodule
